// File: sv/mrcq_pkg.sv
// ============================================================================
// Mouse report coalescing queue package
// Shared types, sizes, codes and an index helper for the queue's modules.
// ============================================================================
package mrcq_pkg;

  // Queue size and the index and count widths that follow from it.
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request actions.
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // One request beat.
  typedef struct packed {
    action_t            action;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic        [2:0]  button_bits;
  } req_t;

  // One result beat.
  typedef struct packed {
    status_t              status;
    logic signed [15:0]   out_x;
    logic signed [15:0]   out_y;
    logic        [2:0]    out_buttons;
    logic [CNT_W-1:0]     fill_level;
  } rsp_t;

  // One stored report.
  typedef struct packed {
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic        [2:0]  buttons;
  } report_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and start the memory read
    logic commit;  // update the queue and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_stat_t;

  // Adds two in-range indexes and wraps the sum back into the queue.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: sv/mrcq_ctrl.sv
// ============================================================================
// Mouse report coalescing queue controller
// Two-state sequencer: capture a request, then commit it once the result
// register is free.
// ============================================================================
module mrcq_ctrl import mrcq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // A request is taken only while no other one is in flight.
  assign req_ready  = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && req_valid;
  assign cmd.commit = (state == S_EXEC) && stat.out_free;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/mrcq_dp.sv
// ============================================================================
// Mouse report coalescing queue datapath
// Report memory, head pointer and fill count, merge adders and the result
// register.
// ============================================================================
module mrcq_dp import mrcq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp
);

  report_t          mem [QUEUE_DEPTH];
  report_t          rd_data;
  req_t             item;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] newest_off;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             mem_we;
  report_t          wr_data;
  rsp_t             rsp_next;
  logic             full;

  assign stat.out_free = !rsp_valid || rsp_ready;
  assign full          = (count == CNT_W'(QUEUE_DEPTH));

  // The read goes to the oldest entry for a pop and the newest for a push.
  assign newest_off = (count == '0) ? '0 : count - CNT_W'(1);
  assign rd_addr    = (req.action == ACT_POP) ? head
                                              : wrap_add(head, newest_off[IDX_W-1:0]);

  // Push, merge and pop decisions on the captured request.
  always_comb begin
    mem_we               = 1'b0;
    wr_addr              = wrap_add(head, count[IDX_W-1:0]);
    wr_data.move_x       = item.move_x;
    wr_data.move_y       = item.move_y;
    wr_data.buttons      = item.button_bits;
    head_next            = head;
    count_next           = count;
    rsp_next.status      = ST_EMPTY;
    rsp_next.out_x       = '0;
    rsp_next.out_y       = '0;
    rsp_next.out_buttons = '0;
    if (item.action == ACT_PUSH) begin
      if (!full) begin
        mem_we          = 1'b1;
        count_next      = count + CNT_W'(1);
        rsp_next.status = ST_APPENDED;
      end else if (rd_data.buttons == item.button_bits) begin
        // Full queue with matching buttons: fold the move into the newest entry.
        mem_we          = 1'b1;
        wr_addr         = wrap_add(head, newest_off[IDX_W-1:0]);
        wr_data.move_x  = rd_data.move_x + item.move_x;
        wr_data.move_y  = rd_data.move_y + item.move_y;
        wr_data.buttons = rd_data.buttons;
        rsp_next.status = ST_MERGED;
      end else begin
        rsp_next.status = ST_DROPPED;
      end
    end else if (count != '0) begin
      head_next            = wrap_add(head, IDX_W'(1));
      count_next           = count - CNT_W'(1);
      rsp_next.status      = ST_POPPED;
      rsp_next.out_x       = rd_data.move_x;
      rsp_next.out_y       = rd_data.move_y;
      rsp_next.out_buttons = rd_data.buttons;
    end
    rsp_next.fill_level = count_next;
  end

  // Report memory with registered read, plus captured request and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= req;
      rd_data <= mem[rd_addr];
    end
    if (cmd.commit && mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  // Queue pointers and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head      <= head_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/mouse_report_coalescing_queue.sv
// ============================================================================
// Mouse report coalescing queue
// FIFO of mouse reports that, when full, folds a move with matching buttons into the newest entry and drops any other.
// ============================================================================
// Each request has a registered read of the report memory (oldest entry for
// a pop, newest for a push), then an update of the queue and a load of the
// result register. A new request is taken only once the last one has been
// committed. The result register holds a finished beat while the next request
// is read; the update stalls only while that register still holds an untaken
// beat. There is no clearing pass after reset: read data is only used from
// entries that a push wrote.
module mouse_report_coalescing_queue import mrcq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mrcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrcq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another was in flight");

  // The fill count never passes the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.fill_level <= CNT_W'(QUEUE_DEPTH))
    else $error("fill level above queue depth");

  // Only a pop that found a report returns report data.
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_POPPED |->
      rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_buttons == '0)
    else $error("report data on a result that is not a pop");

  // A commit never overwrites a result beat that was not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> !$past(cmd.commit))
    else $error("result register overwritten");

endmodule
